// ===== src/etc_pkg.sv =====
// ============================================================================
// etc_pkg: shared types and constants for the epoch-to-calendar converter
// Holds the command and status words between the controller and the
// datapath, the calendar constants and the month-length table.
// ============================================================================
`default_nettype none

package etc_pkg;

    // Reciprocal of 675 scaled by 2^35, rounded up. Seconds shifted right by
    // seven times this value, shifted right by 35, gives whole days, since
    // 86400 is 675 times 128. The rounding error keeps all 25-bit inputs exact.
    localparam logic [25:0] RECIP_DAY = 26'd50903317;

    // Seconds in a day, used to recover the second of the day.
    localparam logic [31:0] SEC_PER_DAY = 32'd86400;

    // Reciprocal of 60 scaled by 2^23, exact for any 17-bit second of the day.
    localparam logic [17:0] RECIP_SOD_MIN = 18'd139811;

    // Reciprocal of 60 scaled by 2^17, exact for any 11-bit minute of the day.
    localparam logic [11:0] RECIP_MIN_HOUR = 12'd2185;

    // Cycle counts of the three division steps, stored as count minus one.
    localparam logic [4:0] CNT_DAY_PASS  = 5'd1;
    localparam logic [4:0] CNT_MIN_PASS  = 5'd0;
    localparam logic [4:0] CNT_HOUR_PASS = 5'd1;

    // Residues of the year 1970 that seed the leap-year tracking.
    localparam logic [1:0] EPOCH_MOD4   = 2'd2;
    localparam logic [6:0] EPOCH_MOD100 = 7'd70;
    localparam logic [8:0] EPOCH_MOD400 = 9'd370;

    localparam logic [8:0] DAYS_LEAP   = 9'd366;
    localparam logic [8:0] DAYS_COMMON = 9'd365;

    // Month indexes with a special meaning.
    localparam logic [3:0] MONTH_FEB  = 4'd1;
    localparam logic [3:0] MONTH_LAST = 4'd11;

    // Datapath operations.
    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_LOAD    = 3'd1,
        OP_DIV     = 3'd2,
        OP_DIV_END = 3'd3,
        OP_YEAR    = 3'd4,
        OP_MONTH   = 3'd5,
        OP_PUBLISH = 3'd6
    } etc_op_t;

    // Which division step is running.
    typedef enum logic [1:0] {
        PH_DAY  = 2'd0,
        PH_MIN  = 2'd1,
        PH_HOUR = 2'd2
    } etc_phase_t;

    typedef struct packed {
        etc_op_t    op;
        etc_phase_t phase;
    } etc_cmd_t;

    typedef struct packed {
        logic year_fit;
        logic month_fit;
    } etc_status_t;

    // Length of a month in days, February depending on the leap flag.
    function automatic logic [4:0] month_days(input logic [3:0] idx, input logic leap);
        logic [4:0] len;
        begin
            case (idx)
                MONTH_FEB: begin
                    len = leap ? 5'd29 : 5'd28;
                end
                4'd3, 4'd5, 4'd8, 4'd10: begin
                    len = 5'd30;
                end
                default: begin
                    len = 5'd31;
                end
            endcase
            return len;
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/epoch_to_calendar.sv =====
// ============================================================================
// epoch_to_calendar: Unix time in seconds to minute, hour, day and month
//
//   Channel  Direction  Handshake            Payload
//   s_       in         s_valid / s_ready    s_epoch_seconds[31:0]
//   m_       out        m_valid / m_ready    m_minute, m_hour, m_day_of_month, m_month
//
// The time from acceptance to result grows with Y, the whole years past
// 1970 (at most 136), and with M, the month index (at most 11); the next
// word can be taken in the cycle after its result is published. A word runs
// through the reciprocal-multiply division steps, then the
// one-year-per-cycle subtract loop and the month subtract loop.
// Reset is synchronous on aresetn and clears only the controller.
// A finished result waits in an output register, so a new word is taken
// while m_ready is low; the controller holds in its finish state only when
// a second result is ready before the first one has been taken.
// ============================================================================
`default_nettype none

module epoch_to_calendar (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_epoch_seconds,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [5:0]       m_minute,
    output logic [4:0]       m_hour,
    output logic [4:0]       m_day_of_month,
    output logic [3:0]       m_month
);

    etc_pkg::etc_cmd_t    cmd;
    etc_pkg::etc_status_t status;

    // Sequencer and handshakes.
    etc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // Divider, calendar loops and result registers.
    etc_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_epoch_seconds (s_epoch_seconds),
        .cmd             (cmd),
        .status          (status),
        .m_minute        (m_minute),
        .m_hour          (m_hour),
        .m_day_of_month  (m_day_of_month),
        .m_month         (m_month)
    );

endmodule

`default_nettype wire

// ===== src/etc_ctrl.sv =====
// ============================================================================
// etc_ctrl: sequencing controller of the epoch-to-calendar converter
// Walks one word through three short division steps, the year loop and
// the month loop, and owns the input and result handshakes.
// ============================================================================
`default_nettype none

module etc_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output etc_pkg::etc_cmd_t         cmd,
    input  wire etc_pkg::etc_status_t status
);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_DIV_DAY  = 7'b0000010,
        ST_DIV_MIN  = 7'b0000100,
        ST_DIV_HOUR = 7'b0001000,
        ST_YEAR     = 7'b0010000,
        ST_MONTH    = 7'b0100000,
        ST_FINISH   = 7'b1000000
    } etc_state_t;

    etc_state_t state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       m_valid_reg, m_valid_next;
    logic       publish;

    // The result slot is free when empty or being drained this cycle.
    assign publish = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    // Next-state and command decode.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = etc_pkg::OP_NONE;
        cmd.phase  = etc_pkg::PH_DAY;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = etc_pkg::OP_LOAD;
                    cnt_next   = etc_pkg::CNT_DAY_PASS;
                    state_next = ST_DIV_DAY;
                end
            end
            ST_DIV_DAY: begin
                cmd.phase = etc_pkg::PH_DAY;
                cnt_next  = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) begin
                    cmd.op     = etc_pkg::OP_DIV_END;
                    cnt_next   = etc_pkg::CNT_MIN_PASS;
                    state_next = ST_DIV_MIN;
                end else begin
                    cmd.op = etc_pkg::OP_DIV;
                end
            end
            ST_DIV_MIN: begin
                cmd.phase = etc_pkg::PH_MIN;
                cnt_next  = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) begin
                    cmd.op     = etc_pkg::OP_DIV_END;
                    cnt_next   = etc_pkg::CNT_HOUR_PASS;
                    state_next = ST_DIV_HOUR;
                end else begin
                    cmd.op = etc_pkg::OP_DIV;
                end
            end
            ST_DIV_HOUR: begin
                cmd.phase = etc_pkg::PH_HOUR;
                cnt_next  = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) begin
                    cmd.op     = etc_pkg::OP_DIV_END;
                    state_next = ST_YEAR;
                end else begin
                    cmd.op = etc_pkg::OP_DIV;
                end
            end
            ST_YEAR: begin
                cmd.op = etc_pkg::OP_YEAR;
                if (status.year_fit) begin
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH: begin
                cmd.op = etc_pkg::OP_MONTH;
                if (status.month_fit) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (publish) begin
                    cmd.op     = etc_pkg::OP_PUBLISH;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid flag.
    always_comb begin
        if (publish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= 5'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // A result appears only out of the finish state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result valid raised outside the finish state");

    // The minute step starts with its full cycle count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV_DAY && cnt_reg == 5'd0)
        |=> (state_reg == ST_DIV_MIN && cnt_reg == etc_pkg::CNT_MIN_PASS))
        else $error("minute pass entered with a wrong step count");

endmodule

`default_nettype wire

// ===== src/etc_dp.sv =====
// ============================================================================
// etc_dp: datapath of the epoch-to-calendar converter
// Reciprocal-multiply division steps for days, minutes and hours, the year
// and month subtract loops with leap-year tracking, and the result registers.
// ============================================================================
`default_nettype none

module etc_dp (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [31:0]       s_epoch_seconds,
    input  wire etc_pkg::etc_cmd_t cmd,
    output etc_pkg::etc_status_t   status,
    output logic [5:0]             m_minute,
    output logic [4:0]             m_hour,
    output logic [4:0]             m_day_of_month,
    output logic [3:0]             m_month
);

    logic [31:0] secs_reg, secs_next;
    logic [16:0] sod_reg, sod_next;
    logic [10:0] mod_reg, mod_next;
    logic [15:0] days_reg, days_next;
    logic [1:0]  mod4_reg, mod4_next;
    logic [6:0]  mod100_reg, mod100_next;
    logic [8:0]  mod400_reg, mod400_next;
    logic [3:0]  month_reg, month_next;
    logic [5:0]  minute_reg, minute_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  out_minute_reg, out_minute_next;
    logic [4:0]  out_hour_reg, out_hour_next;
    logic [4:0]  out_day_reg, out_day_next;
    logic [3:0]  out_month_reg, out_month_next;

    logic [50:0] day_prod;
    logic [31:0] day_secs;
    logic [33:0] min_prod;
    logic [21:0] hour_prod;
    logic [10:0] hour_mins;
    logic        leap;
    logic [8:0]  year_len;
    logic [4:0]  mon_len;
    logic        year_fit;
    logic        month_fit;
    logic [4:0]  day_val;

    // Division steps. The day quotient is a 25 by 26 bit product, the second
    // of the day is what is left of the input, the minute of the day and the
    // hour are smaller reciprocal products, and 60 times the hour is two shifts.
    assign day_prod  = 51'(secs_reg[31:7]) * 51'(etc_pkg::RECIP_DAY);
    assign day_secs  = 32'(days_reg) * etc_pkg::SEC_PER_DAY;
    assign min_prod  = 34'(sod_reg) * 34'(etc_pkg::RECIP_SOD_MIN);
    assign hour_prod = 22'(mod_reg) * 22'(etc_pkg::RECIP_MIN_HOUR);
    assign hour_mins = {hour_reg, 6'd0} - {4'd0, hour_reg, 2'd0};

    // Leap-year flag and the lengths of the current year and month.
    assign leap      = (mod4_reg == 2'd0) && ((mod100_reg != 7'd0) || (mod400_reg == 9'd0));
    assign year_len  = leap ? etc_pkg::DAYS_LEAP : etc_pkg::DAYS_COMMON;
    assign mon_len   = etc_pkg::month_days(month_reg, leap);
    assign year_fit  = (days_reg < {7'd0, year_len});
    assign month_fit = (month_reg == etc_pkg::MONTH_LAST) || (days_reg < {11'd0, mon_len});

    assign status.year_fit  = year_fit;
    assign status.month_fit = month_fit;

    // Day of month, held at 31 should the count ever run past the month.
    assign day_val = (days_reg > 16'd30) ? 5'd31 : 5'(days_reg[4:0] + 5'd1);

    // Next values of the working registers.
    always_comb begin
        secs_next       = secs_reg;
        sod_next        = sod_reg;
        mod_next        = mod_reg;
        days_next       = days_reg;
        mod4_next       = mod4_reg;
        mod100_next     = mod100_reg;
        mod400_next     = mod400_reg;
        month_next      = month_reg;
        minute_next     = minute_reg;
        hour_next       = hour_reg;
        out_minute_next = out_minute_reg;
        out_hour_next   = out_hour_reg;
        out_day_next    = out_day_reg;
        out_month_next  = out_month_reg;
        case (cmd.op)
            etc_pkg::OP_LOAD: begin
                secs_next   = s_epoch_seconds;
                mod4_next   = etc_pkg::EPOCH_MOD4;
                mod100_next = etc_pkg::EPOCH_MOD100;
                mod400_next = etc_pkg::EPOCH_MOD400;
                month_next  = 4'd0;
            end
            etc_pkg::OP_DIV: begin
                case (cmd.phase)
                    etc_pkg::PH_DAY: begin
                        // Whole days since the epoch.
                        days_next = 16'(day_prod >> 35);
                    end
                    etc_pkg::PH_HOUR: begin
                        // Hour from the minute of the day.
                        hour_next = 5'(hour_prod >> 17);
                    end
                    default: begin
                    end
                endcase
            end
            etc_pkg::OP_DIV_END: begin
                case (cmd.phase)
                    etc_pkg::PH_DAY: begin
                        // Seconds left over within the day.
                        sod_next = 17'(secs_reg - day_secs);
                    end
                    etc_pkg::PH_MIN: begin
                        // Minute of the day; the seconds are dropped.
                        mod_next = 11'(min_prod >> 23);
                    end
                    default: begin
                        minute_next = 6'(mod_reg - hour_mins);
                    end
                endcase
            end
            etc_pkg::OP_YEAR: begin
                if (!year_fit) begin
                    days_next   = days_reg - {7'd0, year_len};
                    mod4_next   = mod4_reg + 2'd1;
                    mod100_next = (mod100_reg == 7'd99) ? 7'd0 : 7'(mod100_reg + 7'd1);
                    mod400_next = (mod400_reg == 9'd399) ? 9'd0 : 9'(mod400_reg + 9'd1);
                end
            end
            etc_pkg::OP_MONTH: begin
                if (!month_fit) begin
                    days_next  = days_reg - {11'd0, mon_len};
                    month_next = month_reg + 4'd1;
                end
            end
            etc_pkg::OP_PUBLISH: begin
                out_minute_next = minute_reg;
                out_hour_next   = hour_reg;
                out_day_next    = day_val;
                out_month_next  = month_reg;
            end
            default: begin
            end
        endcase
    end

    // Datapath registers; none of them needs a reset.
    always_ff @(posedge aclk) begin
        secs_reg       <= secs_next;
        sod_reg        <= sod_next;
        mod_reg        <= mod_next;
        days_reg       <= days_next;
        mod4_reg       <= mod4_next;
        mod100_reg     <= mod100_next;
        mod400_reg     <= mod400_next;
        month_reg      <= month_next;
        minute_reg     <= minute_next;
        hour_reg       <= hour_next;
        out_minute_reg <= out_minute_next;
        out_hour_reg   <= out_hour_next;
        out_day_reg    <= out_day_next;
        out_month_reg  <= out_month_next;
    end

    assign m_minute       = out_minute_reg;
    assign m_hour         = out_hour_reg;
    assign m_day_of_month = out_day_reg;
    assign m_month        = out_month_reg;

    // The year loop leaves less than a full year of days.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == etc_pkg::OP_MONTH) |-> (days_reg < {7'd0, etc_pkg::DAYS_LEAP}))
        else $error("month loop started with a full year of days left");

    // The month loop never steps past December.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == etc_pkg::OP_MONTH) |-> (month_reg <= etc_pkg::MONTH_LAST))
        else $error("month index ran past December");

    // A published word carries a time of day in range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == etc_pkg::OP_PUBLISH) |=> (out_hour_reg < 5'd24 && out_minute_reg < 6'd60))
        else $error("published hour or minute out of range");

endmodule

`default_nettype wire

// ===== tb/epoch_to_calendar_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// epoch_to_calendar_test: self-checking bench for the epoch-to-calendar block
// Feeds Unix times through the input channel and checks every result word
// against a calendar computed here. The input words cover the range ends,
// leap days, century years and month ends, followed by random times. Both
// channels stall at random, except for one stretch of steady flow.
// ============================================================================

module epoch_to_calendar_test;

    localparam int unsigned RandomWords = 1400;
    localparam int unsigned DrainCycles = 250;
    localparam int unsigned CycleLimit  = 4000000;
    localparam int unsigned IdlePercent = 28;
    localparam int unsigned SecPerDayTb = 86400;

    // One decoded date, laid out at the widths of the result ports.
    typedef struct packed {
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day_of_month;
        logic [3:0] month;
    } calendar_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_epoch_seconds = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [5:0]  m_minute;
    logic [4:0]  m_hour;
    logic [4:0]  m_day_of_month;
    logic [3:0]  m_month;

    logic [31:0] epoch_queue[$];
    calendar_t   calendar_due[$];
    calendar_t   want;
    int unsigned words_sent = 0;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    logic        steady;

    epoch_to_calendar dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_epoch_seconds (s_epoch_seconds),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_minute        (m_minute),
        .m_hour          (m_hour),
        .m_day_of_month  (m_day_of_month),
        .m_month         (m_month)
    );

    always #2 aclk = ~aclk;

    // Neither side idles while this window of input words is being sent.
    assign steady = (words_sent >= 500) && (words_sent < 800);

    // Gregorian rule: every fourth year, except centuries not divisible by 400.
    function automatic logic gregorian_leap(input int unsigned year);
        return (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
    endfunction

    function automatic int unsigned month_length(input int unsigned month, input logic leap);
        int unsigned len;
        if (month == etc_pkg::MONTH_FEB) begin
            len = leap ? 29 : 28;
        end else begin
            case (month)
                3, 5, 8, 10: len = 30;
                default:     len = 31;
            endcase
        end
        return len;
    endfunction

    // Days in a given year.
    function automatic int unsigned year_length(input int unsigned year);
        return gregorian_leap(year) ? 32'(etc_pkg::DAYS_LEAP) : 32'(etc_pkg::DAYS_COMMON);
    endfunction

    // Expected result word for one input time.
    function automatic calendar_t calendar_of(input logic [31:0] secs);
        int unsigned mins;
        int unsigned hours;
        int unsigned days;
        int unsigned year;
        int unsigned ylen;
        int unsigned month;
        calendar_t   cal;
        mins = secs / 60;
        cal.minute = 6'(mins % 60);
        hours = mins / 60;
        cal.hour = 5'(hours % 24);
        days = hours / 24;
        year = 1970;
        ylen = year_length(year);
        while (days >= ylen) begin
            days -= ylen;
            year++;
            ylen = year_length(year);
        end
        month = 0;
        while (month < etc_pkg::MONTH_LAST &&
               days >= month_length(month, gregorian_leap(year))) begin
            days -= month_length(month, gregorian_leap(year));
            month++;
        end
        if (days > 30) begin
            days = 30;
        end
        cal.day_of_month = 5'(days + 1);
        cal.month = 4'(month);
        return cal;
    endfunction

    // Unix time of a given date and second of the day, used to aim at edges.
    function automatic logic [31:0] epoch_of(input int unsigned year, input int unsigned month,
                                             input int unsigned day, input int unsigned sod);
        longint unsigned days;
        int unsigned     y;
        int unsigned     m;
        days = 0;
        for (y = 1970; y < year; y++) begin
            days += 64'(year_length(y));
        end
        for (m = 0; m < month; m++) begin
            days += 64'(month_length(m, gregorian_leap(year)));
        end
        days += 64'(day - 1);
        return 32'(days * SecPerDayTb + sod);
    endfunction

    // Driver: offers the next pending word when the channel is free, idling at random outside the steady window.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                calendar_due.push_back(calendar_of(s_epoch_seconds));
                words_sent <= words_sent + 1;
            end
            if (!s_valid || s_ready) begin
                if (epoch_queue.size() > 0 &&
                    (steady || $urandom_range(0, 99) >= IdlePercent)) begin
                    s_valid <= 1'b1;
                    s_epoch_seconds <= epoch_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result word against the oldest expected date.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (calendar_due.size() == 0) begin
                    $error({"result word with no date pending: ",
                            "minute %0d hour %0d day %0d month %0d"},
                           m_minute, m_hour, m_day_of_month, m_month);
                    mismatches++;
                end else begin
                    want = calendar_due.pop_front();
                    if (m_minute !== want.minute) begin
                        $error("minute: expected %0d, got %0d", want.minute, m_minute);
                        mismatches++;
                    end
                    if (m_hour !== want.hour) begin
                        $error("hour: expected %0d, got %0d", want.hour, m_hour);
                        mismatches++;
                    end
                    if (m_day_of_month !== want.day_of_month) begin
                        $error("day_of_month: expected %0d, got %0d",
                               want.day_of_month, m_day_of_month);
                        mismatches++;
                    end
                    if (m_month !== want.month) begin
                        $error("month: expected %0d, got %0d", want.month, m_month);
                        mismatches++;
                    end
                end
            end
            m_ready <= steady || ($urandom_range(0, 99) >= IdlePercent);
        end
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int unsigned n;
        int unsigned pick;
        int unsigned year;
        int unsigned month;
        int unsigned day;
        int unsigned sod;

        // Range ends, minute and hour rollovers, and bit patterns.
        epoch_queue.push_back(32'd0);
        epoch_queue.push_back(32'd59);
        epoch_queue.push_back(32'd60);
        epoch_queue.push_back(32'd3599);
        epoch_queue.push_back(32'd3600);
        epoch_queue.push_back(32'd86399);
        epoch_queue.push_back(32'd86400);
        epoch_queue.push_back(32'hFFFF_FFFF);
        epoch_queue.push_back(32'h7FFF_FFFF);
        epoch_queue.push_back(32'h8000_0000);
        epoch_queue.push_back(32'hAAAA_AAAA);
        epoch_queue.push_back(32'h5555_5555);
        // Leap days, year ends, and the century years 2000 (leap) and 2100 (not).
        epoch_queue.push_back(epoch_of(1972, 1, 29, 0));
        epoch_queue.push_back(epoch_of(1972, 11, 31, 86399));
        epoch_queue.push_back(epoch_of(1973, 0, 1, 0));
        epoch_queue.push_back(epoch_of(1999, 11, 31, 86399));
        epoch_queue.push_back(epoch_of(2000, 1, 29, 43200));
        epoch_queue.push_back(epoch_of(2000, 2, 1, 0));
        epoch_queue.push_back(epoch_of(2100, 1, 28, 86399));
        epoch_queue.push_back(epoch_of(2100, 2, 1, 0));
        epoch_queue.push_back(epoch_of(2105, 11, 31, 86399));

        // Random part: full-range times, times at month edges, and the range ends.
        for (n = 0; n < RandomWords; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                epoch_queue.push_back($urandom);
            end else if (pick < 80) begin
                year = $urandom_range(1970, 2105);
                month = $urandom_range(0, 11);
                day = $urandom_range(0, 1) ? 1 : month_length(month, gregorian_leap(year));
                sod = $urandom_range(0, 1) ? $urandom_range(0, 119)
                                           : SecPerDayTb - 1 - $urandom_range(0, 119);
                epoch_queue.push_back(epoch_of(year, month, day, sod));
            end else if (pick < 90) begin
                epoch_queue.push_back($urandom_range(0, 200000000));
            end else begin
                epoch_queue.push_back(32'hFFFF_FFFF - $urandom_range(0, 40000000));
            end
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Sampled away from the active edge so that queue updates have settled.
        while (epoch_queue.size() != 0 || s_valid || calendar_due.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DrainCycles) @(posedge aclk);

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
